[rtl/core/cctl_pkg.sv]
`default_nettype none
package cctl_pkg;

	localparam int unsigned DefTableDepth = 256;

	localparam int unsigned DataW = 72;
	localparam int unsigned ResW  = 64;

	typedef enum logic [1:0] {
		KIND_CLEAR  = 2'd0,
		KIND_INSERT = 2'd1,
		KIND_LOOKUP = 2'd2,
		KIND_RSVD   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FOUND = 2'd1,
		ST_MISS  = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		KEY_SJIS    = 2'd0,
		KEY_JIS     = 2'd1,
		KEY_UTF16   = 2'd2,
		KEY_UNKNOWN = 2'd3
	} key_sel_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] sjis;
		logic [15:0] jis;
		logic [15:0] utf16;
		logic [15:0] code;
	} cmd_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_INS_RD,
		BK_INS_CMP,
		BK_LK_RD,
		BK_LK_CMP,
		BK_OUT
	} bk_state_t;

	function automatic logic [15:0] pick_key(input key_sel_t ks, input logic [47:0] e);
		logic [15:0] k;
		case (ks)
			KEY_SJIS:  k = e[15:0];
			KEY_JIS:   k = e[31:16];
			KEY_UTF16: k = e[47:32];
			default:   k = 16'd0;
		endcase
		return k;
	endfunction

endpackage
`default_nettype wire

[rtl/core/cctl_ram.sv]
`default_nettype none
module cctl_ram #(
	parameter int unsigned Width = 48,
	parameter int unsigned Depth = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]              rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[rtl/core/cctl_front.sv]
`default_nettype none
module cctl_front
	import cctl_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_valid,
	output logic                   s_ready,
	input  wire logic [DataW-1:0]  s_data,
	output logic                   q_valid,
	input  wire logic              q_ready,
	output cmd_t                   q_cmd
);

	cmd_t   buf_q [2];
	logic   wp_q, rp_q;
	logic   [1:0] cnt_q;
	cmd_t   in_cmd;
	logic   push, pop;

	always_comb begin
		in_cmd.kind  = kind_t'(s_data[1:0]);
		in_cmd.sjis  = s_data[17:2];
		in_cmd.jis   = s_data[33:18];
		in_cmd.utf16 = s_data[49:34];
		in_cmd.code  = s_data[65:50];
	end

	assign s_ready = (cnt_q != 2'd2);
	assign push    = s_valid && s_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign pop     = q_valid && q_ready;
	assign q_cmd   = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wp_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count out of range");
	a_full_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !push) else $error("push into full queue");
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 2'd1) else $error("count step");

endmodule
`default_nettype wire

[rtl/core/cctl_back.sv]
`default_nettype none
module cctl_back
	import cctl_pkg::*;
#(
	parameter int unsigned TableDepth = DefTableDepth
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [1:0]       key_select,
	input  wire logic             q_valid,
	output logic                  q_ready,
	input  cmd_t                  q_cmd,
	output logic                  m_valid,
	input  wire logic             m_ready,
	output logic [ResW-1:0]       m_data
);

	localparam int unsigned AW = $clog2(TableDepth);
	localparam int unsigned CW = AW + 1;

	bk_state_t state_q, state_d;
	logic [CW-1:0] count_q;
	cmd_t          cmd_q;
	logic [CW-1:0] pos_q;
	logic [CW:0]   lo_q, hi_q;
	logic [CW:0]   mid;
	logic [AW-1:0] mid_q;
	logic [1:0]    st_q;
	logic [47:0]   fnd_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [47:0]   wdata, rdata;
	logic [15:0]   nkey, hkey;
	key_sel_t      ks;

	cctl_ram #(.Width(48), .Depth(TableDepth)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	assign ks   = key_sel_t'(key_select);
	assign nkey = pick_key(ks, {cmd_q.utf16, cmd_q.jis, cmd_q.sjis});
	assign hkey = pick_key(ks, rdata);
	assign mid  = (lo_q + hi_q) >> 1;

	assign q_ready = (state_q == BK_IDLE);
	assign m_valid = (state_q == BK_OUT);
	assign m_data  = {5'd0, 9'(count_q), fnd_q, st_q};

	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		waddr   = pos_q[AW-1:0];
		wdata   = rdata;
		raddr   = mid_q;
		case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					case (q_cmd.kind)
						KIND_INSERT: begin
							if (count_q == CW'(TableDepth)) state_d = BK_OUT;
							else if (count_q == '0) state_d = BK_INS_CMP;
							else state_d = BK_INS_RD;
						end
						KIND_LOOKUP: begin
							if (ks == KEY_UNKNOWN || count_q == '0) state_d = BK_OUT;
							else state_d = BK_LK_RD;
						end
						default: state_d = BK_OUT;
					endcase
				end
			end
			BK_INS_RD: begin
				raddr   = AW'(pos_q - 1'b1);
				state_d = BK_INS_CMP;
			end
			BK_INS_CMP: begin
				raddr = AW'(pos_q - 2'd2);
				we    = 1'b1;
				if (pos_q != '0 && hkey > nkey) begin
					wdata = rdata;
					if (pos_q == CW'(1)) state_d = BK_INS_CMP;
				end else begin
					wdata   = {cmd_q.utf16, cmd_q.jis, cmd_q.sjis};
					state_d = BK_OUT;
				end
			end
			BK_LK_RD: begin
				raddr   = mid[AW-1:0];
				state_d = BK_LK_CMP;
			end
			BK_LK_CMP: begin
				if (cmd_q.code == hkey) state_d = BK_OUT;
				else if (cmd_q.code < hkey) begin
					if ({1'b0, mid_q} == lo_q[AW:0] && lo_q[CW] == 1'b0) state_d = BK_OUT;
					else state_d = BK_LK_RD;
				end else begin
					if (CW'(mid_q) == hi_q[CW-1:0]) state_d = BK_OUT;
					else state_d = BK_LK_RD;
				end
			end
			BK_OUT: begin
				if (m_ready) state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_IDLE && q_valid && q_cmd.kind == KIND_CLEAR) count_q <= '0;
			if (state_q == BK_INS_CMP && state_d == BK_OUT) count_q <= count_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				cmd_q <= q_cmd;
				pos_q <= count_q;
				lo_q  <= '0;
				hi_q  <= {1'b0, count_q} - 1'b1;
				fnd_q <= '0;
				st_q  <= ST_DONE;
				if (q_cmd.kind == KIND_INSERT && count_q == CW'(TableDepth)) st_q <= ST_FULL;
				if (q_cmd.kind == KIND_LOOKUP) st_q <= ST_MISS;
			end
			BK_INS_RD: ;
			BK_INS_CMP: begin
				if (pos_q != '0 && hkey > nkey) begin
					pos_q <= pos_q - 1'b1;
				end
			end
			BK_LK_RD: mid_q <= mid[AW-1:0];
			BK_LK_CMP: begin
				if (cmd_q.code == hkey) begin
					st_q  <= ST_FOUND;
					fnd_q <= rdata;
				end else if (cmd_q.code < hkey) begin
					hi_q <= {2'b0, mid_q} - 1'b1;
				end else begin
					lo_q <= {2'b0, mid_q} + 1'b1;
				end
			end
			default: ;
		endcase
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TableDepth)) else $error("count exceeds depth");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid && !m_ready |=> m_valid && $stable(m_data)) else $error("result changed");
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid && st_q == ST_FULL |-> count_q == CW'(TableDepth)) else $error("bad full");

endmodule
`default_nettype wire

[rtl/core/charset_code_table_lookup_top.sv]
`default_nettype none
// Sorted code-triple table: inserts keep entries ordered on the code picked by key_select,
// lookups run a midpoint binary search over a single-port-read RAM. One beat in gives
// one beat out. Each lookup probe issues the address, then compares on the registered
// RAM read. An insert moves one entry per cycle, and a clear resets the stored count.
// A two-entry queue between the input side and the table engine lets both stall alone.
module charset_code_table_lookup_top
	import cctl_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = DefTableDepth
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_wdata,
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	// kind, entry_sjis, entry_jis, entry_utf16, search_code
	input  wire logic [DataW-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	// status, found_sjis, found_jis, found_utf16, stored_count
	output logic [ResW-1:0]        m_axis_tdata
);

	logic [1:0] key_q;
	logic       q_valid, q_ready;
	cmd_t       q_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= KEY_UNKNOWN;
		end else if (cfg_we) begin
			key_q <= cfg_wdata;
		end
	end

	cctl_front u_front (
		.clk(clk), .arst_n(arst_n),
		.s_valid(s_axis_tvalid), .s_ready(s_axis_tready), .s_data(s_axis_tdata),
		.q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
	);

	cctl_back #(.TableDepth(TABLE_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n), .key_select(key_q),
		.q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
		.m_valid(m_axis_tvalid), .m_ready(m_axis_tready), .m_data(m_axis_tdata)
	);

endmodule
`default_nettype wire
